// ===== rtl/ssk_pkg.sv =====
// shared types, constants and helper functions of the spaced-seed k-mer indexer
// no dependencies; every other file refers to it by scoped names
package ssk_pkg;

	// window length (longest shape) and fixed field widths
	localparam int WIN_LEN    = 32;
	localparam int MASK_W     = 32;
	localparam int WORD_W     = 32;
	localparam int CHAR_W     = 8;
	localparam int MAP_W      = 8;
	localparam int BASE_W     = 3;
	localparam int CODE_W     = 2;
	localparam int MASK_IDX_W = $clog2(MASK_W);
	localparam int CNT_W      = $clog2((WIN_LEN > MASK_W ? WIN_LEN : MASK_W) + 1);
	localparam int DIGITS     = WORD_W / CODE_W;

	// rank computation works on groups of bases
	localparam int GRP_LEN = 8;
	localparam int NGRP    = (WIN_LEN + GRP_LEN - 1) / GRP_LEN;
	localparam int LP_W    = $clog2(GRP_LEN);
	localparam int GT_W    = $clog2(GRP_LEN + 1);

	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MASK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_LOWER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NT_CODE_MAP  = 2'd2;

	localparam logic [MASK_W-1:0] RST_SHAPE_MASK  = 32'd4095;
	localparam logic [MAP_W-1:0]  RST_NT_CODE_MAP = 8'd228;

	typedef logic [BASE_W-1:0] base_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [LP_W-1:0]   lp_t;
	typedef logic [GT_W-1:0]   gt_t;

	// base classes
	localparam base_t BASE_A = 3'd0;
	localparam base_t BASE_C = 3'd1;
	localparam base_t BASE_G = 3'd2;
	localparam base_t BASE_T = 3'd3;
	localparam base_t BASE_N = 3'd4;

	// characters
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
	localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
	localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;

	localparam word_t AMB_INDEX = 32'h8000_0000;

	typedef struct packed {
		logic [MASK_W-1:0] shape_mask;
		logic              ignore_lower;
		logic [MAP_W-1:0]  nt_code_map;
	} cfg_t;

	// one queue entry: window by age (entry 0 newest) and window start
	typedef struct packed {
		base_t [WIN_LEN-1:0] win;
		word_t               wstart;
	} qent_t;

	function automatic base_t classify(logic [CHAR_W-1:0] ch, logic no_fold);
		logic [CHAR_W-1:0] c;
		base_t             b;
		c = ch;
		if (!no_fold && ch >= CH_LA && ch <= CH_LZ) begin
			c = ch - CASE_GAP;
		end
		case (c)
			CH_A:    b = BASE_A;
			CH_C:    b = BASE_C;
			CH_G:    b = BASE_G;
			CH_T:    b = BASE_T;
			default: b = BASE_N;
		endcase
		return b;
	endfunction

	// highest sampled offset plus one, one for an empty mask
	function automatic cnt_t span_of(logic [MASK_W-1:0] m);
		cnt_t s;
		s = cnt_t'(1);
		for (int i = 0; i < MASK_W; i++) begin
			if (m[i] && i < WIN_LEN) begin
				s = cnt_t'(i + 1);
			end
		end
		return s;
	endfunction

	function automatic code_t map_code(logic [MAP_W-1:0] map, base_t b);
		code_t c;
		case (b[1:0])
			2'd0:    c = map[1:0];
			2'd1:    c = map[3:2];
			2'd2:    c = map[5:4];
			default: c = map[7:6];
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/ssk_front.sv =====
// front part: classifies characters, shifts the base window, keeps the counts
// and decides which beats produce a result; uses ssk_pkg
module ssk_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssk_pkg::cfg_t                cfg,
	input  logic                         take,
	input  logic [ssk_pkg::CHAR_W-1:0]   nt_char,
	input  logic                         seq_start,
	output logic                         push,
	output ssk_pkg::qent_t               ent
);

	ssk_pkg::base_t [ssk_pkg::WIN_LEN-1:0] win_q;
	ssk_pkg::base_t [ssk_pkg::WIN_LEN-1:0] win_nxt;
	ssk_pkg::cnt_t                          fill_q;
	ssk_pkg::cnt_t                          fill_base;
	ssk_pkg::cnt_t                          fill_nxt;
	ssk_pkg::cnt_t                          span;
	ssk_pkg::word_t                         pos_q;
	ssk_pkg::word_t                         pos_base;
	ssk_pkg::word_t                         pos_nxt;

	always_comb begin
		span      = ssk_pkg::span_of(cfg.shape_mask);
		// a new sequence restarts both counts; older window entries are never sampled
		fill_base = seq_start ? '0 : fill_q;
		pos_base  = seq_start ? '0 : pos_q;
		fill_nxt  = (fill_base == ssk_pkg::cnt_t'(ssk_pkg::WIN_LEN)) ? fill_base
		                                                            : fill_base + 1'b1;
		pos_nxt   = pos_base + 1'b1;
		win_nxt[0] = ssk_pkg::classify(nt_char, cfg.ignore_lower);
		for (int a = 1; a < ssk_pkg::WIN_LEN; a++) begin
			win_nxt[a] = win_q[a-1];
		end
		push       = take && (fill_nxt >= span);
		ent.win    = win_nxt;
		ent.wstart = pos_nxt - ssk_pkg::word_t'(span);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (take) begin
			fill_q <= fill_nxt;
			pos_q  <= pos_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			win_q <= win_nxt;
		end
	end

endmodule

// ===== rtl/ssk_queue.sv =====
// short queue of window snapshots between front and back
// uses ssk_pkg for the entry type and depth
module ssk_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ssk_pkg::qent_t push_ent,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output ssk_pkg::qent_t head
);

	ssk_pkg::qent_t                mem_q [ssk_pkg::QDEPTH];
	logic [ssk_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ssk_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ssk_pkg::QCNT_W-1:0]    cnt_q;

	assign full      = (cnt_q == ssk_pkg::QCNT_W'(ssk_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule

// ===== rtl/ssk_back.sv =====
// back part: selects sampled bases, ranks them and packs the k-mer index
// four register stages with a common advance; uses ssk_pkg
module ssk_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssk_pkg::cfg_t                cfg,
	input  logic                         q_valid,
	input  ssk_pkg::qent_t               q_head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ssk_pkg::word_t               kmer_index,
	output logic                         has_ambiguous,
	output ssk_pkg::word_t               window_start
);

	logic adv;

	// stage 1: sampled ages, ambiguity, mapped codes
	logic [ssk_pkg::WIN_LEN-1:0]              sel_c;
	logic                                     amb_c;
	ssk_pkg::code_t [ssk_pkg::WIN_LEN-1:0]    code_c;
	ssk_pkg::cnt_t                            span;
	logic                                     v_s1;
	logic [ssk_pkg::WIN_LEN-1:0]              sel_s1;
	logic                                     amb_s1;
	ssk_pkg::code_t [ssk_pkg::WIN_LEN-1:0]    code_s1;
	ssk_pkg::word_t                           wstart_s1;

	// stage 2: counts inside groups
	ssk_pkg::lp_t [ssk_pkg::WIN_LEN-1:0]      lp_c;
	ssk_pkg::gt_t [ssk_pkg::NGRP-1:0]         gt_c;
	logic                                     v_s2;
	logic [ssk_pkg::WIN_LEN-1:0]              sel_s2;
	logic                                     amb_s2;
	ssk_pkg::code_t [ssk_pkg::WIN_LEN-1:0]    code_s2;
	ssk_pkg::lp_t [ssk_pkg::WIN_LEN-1:0]      lp_s2;
	ssk_pkg::gt_t [ssk_pkg::NGRP-1:0]         gt_s2;
	ssk_pkg::word_t                           wstart_s2;

	// stage 3: full rank of each sampled base
	ssk_pkg::cnt_t [ssk_pkg::NGRP-1:0]        gbase_c;
	ssk_pkg::cnt_t [ssk_pkg::WIN_LEN-1:0]     rank_c;
	logic                                     v_s3;
	logic [ssk_pkg::WIN_LEN-1:0]              sel_s3;
	logic                                     amb_s3;
	ssk_pkg::code_t [ssk_pkg::WIN_LEN-1:0]    code_s3;
	ssk_pkg::cnt_t [ssk_pkg::WIN_LEN-1:0]     rank_s3;
	ssk_pkg::word_t                           wstart_s3;

	// output register
	ssk_pkg::word_t                           kmer_c;
	logic                                     out_valid_q;
	ssk_pkg::word_t                           kmer_q;
	logic                                     amb_q;
	ssk_pkg::word_t                           wstart_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && q_valid;

	always_comb begin
		int k;
		span  = ssk_pkg::span_of(cfg.shape_mask);
		amb_c = 1'b0;
		k     = 0;
		for (int a = 0; a < ssk_pkg::WIN_LEN; a++) begin
			// age a holds window offset span-1-a
			k = int'(span) - 1 - a;
			sel_c[a]  = (k >= 0) ? cfg.shape_mask[k[ssk_pkg::MASK_IDX_W-1:0]] : 1'b0;
			amb_c     = amb_c | (sel_c[a] && (q_head.win[a] >= ssk_pkg::BASE_N));
			code_c[a] = ssk_pkg::map_code(cfg.nt_code_map, q_head.win[a]);
		end
	end

	always_comb begin
		ssk_pkg::gt_t cnt;
		cnt  = '0;
		lp_c = '0;
		for (int g = 0; g < ssk_pkg::NGRP; g++) begin
			cnt = '0;
			for (int j = 0; j < ssk_pkg::GRP_LEN; j++) begin
				if (g * ssk_pkg::GRP_LEN + j < ssk_pkg::WIN_LEN) begin
					lp_c[g * ssk_pkg::GRP_LEN + j] = ssk_pkg::lp_t'(cnt);
					cnt = cnt + ssk_pkg::gt_t'(sel_s1[g * ssk_pkg::GRP_LEN + j]);
				end
			end
			gt_c[g] = cnt;
		end
	end

	always_comb begin
		gbase_c[0] = '0;
		for (int g = 1; g < ssk_pkg::NGRP; g++) begin
			gbase_c[g] = gbase_c[g-1] + ssk_pkg::cnt_t'(gt_s2[g-1]);
		end
		rank_c = '0;
		for (int g = 0; g < ssk_pkg::NGRP; g++) begin
			for (int j = 0; j < ssk_pkg::GRP_LEN; j++) begin
				if (g * ssk_pkg::GRP_LEN + j < ssk_pkg::WIN_LEN) begin
					rank_c[g * ssk_pkg::GRP_LEN + j] =
						gbase_c[g] + ssk_pkg::cnt_t'(lp_s2[g * ssk_pkg::GRP_LEN + j]);
				end
			end
		end
	end

	// rank counts later sampled bases, which is the digit position of this one
	always_comb begin
		ssk_pkg::code_t dig;
		dig    = '0;
		kmer_c = '0;
		for (int d = 0; d < ssk_pkg::DIGITS; d++) begin
			dig = '0;
			for (int a = 0; a < ssk_pkg::WIN_LEN; a++) begin
				if (sel_s3[a] && rank_s3[a] == ssk_pkg::cnt_t'(d)) begin
					dig = dig | code_s3[a];
				end
			end
			kmer_c[d * ssk_pkg::CODE_W +: ssk_pkg::CODE_W] = dig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s1    <= sel_c;
			amb_s1    <= amb_c;
			code_s1   <= code_c;
			wstart_s1 <= q_head.wstart;
			sel_s2    <= sel_s1;
			amb_s2    <= amb_s1;
			code_s2   <= code_s1;
			lp_s2     <= lp_c;
			gt_s2     <= gt_c;
			wstart_s2 <= wstart_s1;
			sel_s3    <= sel_s2;
			amb_s3    <= amb_s2;
			code_s3   <= code_s2;
			rank_s3   <= rank_c;
			wstart_s3 <= wstart_s2;
			kmer_q    <= amb_s3 ? ssk_pkg::AMB_INDEX : kmer_c;
			amb_q     <= amb_s3;
			wstart_q  <= wstart_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign kmer_index    = kmer_q;
	assign has_ambiguous = amb_q;
	assign window_start  = wstart_q;

endmodule

// ===== rtl/spaced_seed_kmer_index.sv =====
// spaced-seed k-mer indexer: one character beat per cycle in, one index beat per cycle out
// while no stall holds them; a taken character beat passes the queue write, then three
// back stages and the output register in a common pipe; throughput is 1 beat per cycle
// unless stalled, and the back pipe moves whenever the output register is free
// reset: arst_n clears counts, queue and pipe valids; registers return to mask 4095,
// lowercase folding and code map 228
module spaced_seed_kmer_index (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [ssk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssk_pkg::MASK_W-1:0]      cfg_data,
	// character channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ssk_pkg::CHAR_W-1:0]      nt_char,
	input  logic                            seq_start,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ssk_pkg::WORD_W-1:0]      kmer_index,
	output logic                            has_ambiguous,
	output logic [ssk_pkg::WORD_W-1:0]      window_start
);

	ssk_pkg::cfg_t  cfg_q;
	logic           take;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_not_empty;
	ssk_pkg::qent_t q_in;
	ssk_pkg::qent_t q_head;

	// configuration registers; writes outside the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_mask   <= ssk_pkg::RST_SHAPE_MASK;
			cfg_q.ignore_lower <= 1'b0;
			cfg_q.nt_code_map  <= ssk_pkg::RST_NT_CODE_MAP;
		end else if (cfg_we) begin
			case (cfg_index)
				ssk_pkg::REG_SHAPE_MASK:   cfg_q.shape_mask   <= cfg_data;
				ssk_pkg::REG_IGNORE_LOWER: cfg_q.ignore_lower <= cfg_data[0];
				ssk_pkg::REG_NT_CODE_MAP:  cfg_q.nt_code_map  <= cfg_data[ssk_pkg::MAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// the front only waits for queue room, never for the result side directly
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	ssk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.take      (take),
		.nt_char   (nt_char),
		.seq_start (seq_start),
		.push      (q_push),
		.ent       (q_in)
	);

	// window snapshots waiting for the back pipe
	ssk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_ent  (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// packing pipe and output register
	ssk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_not_empty),
		.q_head        (q_head),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kmer_index    (kmer_index),
		.has_ambiguous (has_ambiguous),
		.window_start  (window_start)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("queue read while empty");

	a_amb_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_ambiguous) |-> (kmer_index == ssk_pkg::AMB_INDEX))
		else $error("ambiguous beat without the ambiguous index");

	a_start_short: assert property (@(posedge clk) disable iff (!arst_n)
		(take && seq_start && (ssk_pkg::span_of(cfg_q.shape_mask) > ssk_pkg::cnt_t'(1)))
		|-> !q_push)
		else $error("result queued before the window covers the shape");
`endif

endmodule

// ===== verif/tb_spaced_seed_kmer_index.sv =====
// testbench for spaced_seed_kmer_index: streams sequences under several shape, case and
// code map settings, predicts every index beat and checks each one as it comes out
// depends on ssk_pkg and the spaced_seed_kmer_index rtl
`timescale 1ns / 100ps

module tb_spaced_seed_kmer_index;

	localparam int CLK_HALF    = 5;
	localparam int RUN_LIMIT   = 200000;
	localparam int SETTLE_CYC  = 10;
	localparam int HOLD_CYC    = 80;
	localparam int IDLE_PCT    = 34;

	// one character beat waiting to be sent
	typedef struct {
		logic [ssk_pkg::CHAR_W-1:0] ch;
		logic                       first;
	} char_beat_t;

	// one index beat the block should produce
	typedef struct {
		logic [ssk_pkg::WORD_W-1:0] kmer;
		logic                       amb;
		logic [ssk_pkg::WORD_W-1:0] wstart;
	} kmer_beat_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [ssk_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [ssk_pkg::MASK_W-1:0]        cfg_data;
	logic                              in_valid;
	logic                              in_stall;
	logic [ssk_pkg::CHAR_W-1:0]        nt_char;
	logic                              seq_start;
	logic                              out_valid;
	logic                              out_stall;
	logic [ssk_pkg::WORD_W-1:0]        kmer_index;
	logic                              has_ambiguous;
	logic [ssk_pkg::WORD_W-1:0]        window_start;

	char_beat_t char_q[$];
	kmer_beat_t kmer_q[$];

	// predictor copy of the registers and the window state
	logic [ssk_pkg::MASK_W-1:0] cur_mask;
	logic                       cur_lower;
	logic [ssk_pkg::MAP_W-1:0]  cur_map;
	ssk_pkg::base_t             seq_win [ssk_pkg::WIN_LEN];
	int unsigned                seq_fill;
	logic [ssk_pkg::WORD_W-1:0] seq_pos;

	int  cyc;
	int  err_cnt;
	int  push_cnt;
	int  acc_cnt;
	int  idx_seen;
	int  hold_left;
	int  hold_runs;
	logic in_taken;
	logic calm;

	spaced_seed_kmer_index dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.nt_char       (nt_char),
		.seq_start     (seq_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kmer_index    (kmer_index),
		.has_ambiguous (has_ambiguous),
		.window_start  (window_start)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// long stretches where neither side idles
	assign calm = (cyc % 3000) >= 2500;

	// map one character to a base class, folding case unless lowercase counts as N
	function automatic ssk_pkg::base_t base_of(logic [7:0] ch, logic lower_is_n);
		logic [7:0] up;
		up = ch;
		if (!lower_is_n && ch >= "a" && ch <= "z") begin
			up = ch - 8'd32;
		end
		case (up)
			"A":     return ssk_pkg::BASE_A;
			"C":     return ssk_pkg::BASE_C;
			"G":     return ssk_pkg::BASE_G;
			"T":     return ssk_pkg::BASE_T;
			default: return ssk_pkg::BASE_N;
		endcase
	endfunction

	// shift one character into the window and work out the index beat it causes, if any
	function automatic void advance_window(input logic [7:0] ch, input logic first,
			output bit got, output kmer_beat_t res);
		int unsigned    span;
		bit             hit_n;
		ssk_pkg::base_t b;
		if (first) begin
			foreach (seq_win[i]) seq_win[i] = ssk_pkg::BASE_N;
			seq_fill = 0;
			seq_pos  = '0;
		end
		for (int i = ssk_pkg::WIN_LEN - 1; i > 0; i--) begin
			seq_win[i] = seq_win[i-1];
		end
		seq_win[0] = base_of(ch, cur_lower);
		if (seq_fill < ssk_pkg::WIN_LEN) begin
			seq_fill++;
		end
		seq_pos++;

		// span is the highest sampled offset plus one, an empty mask counts as one
		span = 1;
		for (int i = 0; i < ssk_pkg::WIN_LEN; i++) begin
			if (cur_mask[i]) span = i + 1;
		end
		got = seq_fill >= span;

		// offset 0 is the oldest base of the window, packed most significant first
		res.kmer = '0;
		res.amb  = 1'b0;
		hit_n    = 1'b0;
		for (int i = 0; i < span; i++) begin
			if (cur_mask[i] && !hit_n) begin
				b = seq_win[span - 1 - i];
				if (b == ssk_pkg::BASE_N) begin
					hit_n    = 1'b1;
					res.kmer = ssk_pkg::AMB_INDEX;
					res.amb  = 1'b1;
				end else begin
					res.kmer = (res.kmer << 2) + cur_map[2*b[1:0] +: 2];
				end
			end
		end
		res.wstart = seq_pos - span;
	endfunction

	// cycle count and the overall time limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// character driver: a new beat goes out only once the current one has been taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (char_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				nt_char   <= char_q[0].ch;
				seq_start <= char_q[0].first;
				char_q.delete(0);
				in_valid  <= 1'b1;
			end else begin
				in_valid  <= 1'b0;
			end
		end
	end

	// result side: random stalls, plus long hold-offs while plenty of characters wait
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (arst_n && char_q.size() > 80 && kmer_q.size() > 0
				&& (hold_runs == 0 || (hold_runs == 1 && idx_seen > 800))) begin
			hold_left <= HOLD_CYC;
			hold_runs <= hold_runs + 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// predictor on accepted characters, checker on accepted index beats
	always @(posedge clk) begin
		bit         got;
		kmer_beat_t res;
		kmer_beat_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				acc_cnt++;
				advance_window(nt_char, seq_start, got, res);
				if (got) kmer_q.push_back(res);
			end
			if (out_valid && !out_stall) begin
				idx_seen++;
				if (kmer_q.size() == 0) begin
					$display("%0t: index beat with none expected: kmer_index %h amb %b start %0d",
						$time, kmer_index, has_ambiguous, window_start);
					err_cnt++;
				end else begin
					want = kmer_q.pop_front();
					if (kmer_index !== want.kmer) begin
						$display("%0t: kmer_index expected %h actual %h",
							$time, want.kmer, kmer_index);
						err_cnt++;
					end
					if (has_ambiguous !== want.amb) begin
						$display("%0t: has_ambiguous expected %b actual %b",
							$time, want.amb, has_ambiguous);
						err_cnt++;
					end
					if (window_start !== want.wstart) begin
						$display("%0t: window_start expected %0d actual %0d",
							$time, want.wstart, window_start);
						err_cnt++;
					end
				end
			end
		end
	end

	task automatic push_char(input logic [7:0] ch, input logic first);
		char_beat_t cb;
		cb.ch    = ch;
		cb.first = first;
		char_q.push_back(cb);
		push_cnt++;
	endtask

	task automatic push_str(input string s, input logic first);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i], first && i == 0);
		end
	endtask

	// sequences of random length: mostly clean bases, junk_pct percent N or arbitrary bytes,
	// some lowercase, the odd sequence without a start mark and the odd restart mid-sequence
	task automatic gen_seqs(input int n, input int junk_pct);
		int         left;
		int         len;
		int         r;
		logic [7:0] c;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 40);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(99);
				if (r < junk_pct / 2) begin
					c = 8'($urandom_range(255));
				end else if (r < junk_pct) begin
					c = $urandom_range(1) ? "N" : "n";
				end else begin
					case ($urandom_range(3))
						0:       c = "A";
						1:       c = "C";
						2:       c = "G";
						default: c = "T";
					endcase
					if ($urandom_range(9) == 0) c = c | 8'h20;
				end
				push_char(c, (i == 0 && $urandom_range(9) != 0) || $urandom_range(199) == 0);
			end
			left -= len;
		end
	endtask

	// wait until every character is taken and every index beat has come out, then let
	// beats that cause no index leave the pipe
	task automatic drain();
		do @(negedge clk);
		while (char_q.size() != 0 || acc_cnt != push_cnt || kmer_q.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ssk_pkg::CFG_IDX_W-1:0] idx,
			input logic [ssk_pkg::MASK_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			ssk_pkg::REG_SHAPE_MASK:   cur_mask  = val;
			ssk_pkg::REG_IGNORE_LOWER: cur_lower = val[0];
			ssk_pkg::REG_NT_CODE_MAP:  cur_map   = val[ssk_pkg::MAP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] mask, input logic lower, input logic [7:0] map);
		write_reg(ssk_pkg::REG_SHAPE_MASK, mask);
		write_reg(ssk_pkg::REG_IGNORE_LOWER, {31'd0, lower});
		write_reg(ssk_pkg::REG_NT_CODE_MAP, {24'd0, map});
	endtask

	initial begin
		logic [31:0] rmask;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		nt_char   = '0;
		seq_start = 1'b0;
		out_stall = 1'b0;
		in_taken  = 1'b0;
		cyc       = 0;
		err_cnt   = 0;
		push_cnt  = 0;
		acc_cnt   = 0;
		idx_seen  = 0;
		hold_left = 0;
		hold_runs = 0;
		cur_mask  = ssk_pkg::RST_SHAPE_MASK;
		cur_lower = 1'b0;
		cur_map   = ssk_pkg::RST_NT_CODE_MAP;
		seq_fill  = 0;
		seq_pos   = '0;
		foreach (seq_win[i]) seq_win[i] = ssk_pkg::BASE_N;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset settings, stream starts with no start mark: clean bases, lowercase
		// folding, byte extremes, N and a letter outside the alphabet, then a restart
		push_str("ACGTACGTACGTacgt", 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'hff, 1'b0);
		push_char("N", 1'b0);
		push_char("z", 1'b0);
		push_str("GATTACA", 1'b1);

		// random sequences on reset settings; the sender pauses for a full drain halfway
		gen_seqs(100, 15);
		drain();
		gen_seqs(100, 15);
		drain();

		// full 32-base span, only the last 16 sampled codes survive, reversed code map
		set_config(32'hffff_ffff, 1'b0, 8'h1b);
		gen_seqs(250, 2);
		drain();

		// single-base shape with lowercase treated as N and everything mapped to zero
		set_config(32'h0000_0001, 1'b1, 8'h00);
		gen_seqs(150, 10);
		drain();

		// empty shape: every character gives a zero index at its own position
		set_config(32'h0000_0000, 1'b0, 8'hff);
		gen_seqs(100, 10);
		drain();

		// widest gap: only the two window ends are sampled
		set_config(32'h8000_0001, 1'b1, 8'he4);
		gen_seqs(200, 2);
		drain();

		// random shapes, many of them short, with random case handling and code maps
		for (int p = 0; p < 4; p++) begin
			rmask = $urandom;
			if (p[0]) rmask = rmask & ((32'd1 << $urandom_range(1, 16)) - 1);
			set_config(rmask, 1'($urandom_range(1)), 8'($urandom_range(255)));
			gen_seqs(200, 6);
			drain();
		end

		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== spaced_seed_kmer_index.f =====
rtl/ssk_pkg.sv
rtl/ssk_front.sv
rtl/ssk_queue.sv
rtl/ssk_back.sv
rtl/spaced_seed_kmer_index.sv
verif/tb_spaced_seed_kmer_index.sv
